// ===== sv/afx_pkg.sv =====
package afx_pkg;

	localparam int FRAC_BITS = 24;
	localparam int MAX_STEPS = 24;
	localparam int ZW = 27;
	localparam int TW = 29;
	localparam int AW = 16;
	localparam int RW = TW - 1 - (FRAC_BITS - 13);

	localparam logic signed [TW-1:0] PI_Q24 = 29'sd52707179;
	localparam logic signed [TW-1:0] TWO_PI_Q24 = 29'sd105414357;
	localparam logic signed [TW-1:0] ROUND_HALF = 29'sd1024;

	localparam logic [AW-1:0] ZERO_Q13 = 16'd0;
	localparam logic [AW-1:0] PI_Q13 = 16'd25736;
	localparam logic [AW-1:0] HALF_PI_Q13 = 16'd12868;
	localparam logic [AW-1:0] THREE_HALF_PI_Q13 = 16'd38604;
	localparam logic [RW-1:0] ANGLE_MAX_Q13 = RW'(51471);

	typedef struct packed {
		logic special;
		logic [AW-1:0] fixed_angle;
		logic undef;
		logic x_pos;
		logic y_pos;
		logic y_neg;
		logic base_pi;
	} side_t;

	function automatic logic signed [ZW-1:0] atan_q24(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0: v = 27'sd13176795;
			1: v = 27'sd7778716;
			2: v = 27'sd4110060;
			3: v = 27'sd2086331;
			4: v = 27'sd1047214;
			5: v = 27'sd524117;
			6: v = 27'sd262123;
			7: v = 27'sd131069;
			8: v = 27'sd65536;
			9: v = 27'sd32768;
			10: v = 27'sd16384;
			11: v = 27'sd8192;
			12: v = 27'sd4096;
			13: v = 27'sd2048;
			14: v = 27'sd1024;
			15: v = 27'sd512;
			16: v = 27'sd256;
			17: v = 27'sd128;
			18: v = 27'sd64;
			19: v = 27'sd32;
			20: v = 27'sd16;
			21: v = 27'sd8;
			22: v = 27'sd4;
			23: v = 27'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/afx_pre.sv =====
module afx_pre import afx_pkg::*; #(
	parameter int CW = 16,
	parameter int DW = 42
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_vld,
	input  logic [CW-1:0]        x_in,
	input  logic [CW-1:0]        y_in,
	output logic                 out_vld,
	output logic signed [DW-1:0] x_out,
	output logic signed [DW-1:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output side_t                side_out
);

	logic signed [DW-1:0] xe, ye, xr, yr;
	logic x_zero, y_zero;
	side_t side;
	logic vld_s1;
	logic signed [DW-1:0] x_s1, y_s1;
	side_t side_s1;

	always_comb begin
		xe = signed'({{(DW-CW){x_in[CW-1]}}, x_in}) <<< FRAC_BITS;
		ye = signed'({{(DW-CW){y_in[CW-1]}}, y_in}) <<< FRAC_BITS;
		if (x_in[CW-1]) begin
			xr = -xe;
			yr = -ye;
		end else begin
			xr = xe;
			yr = ye;
		end
		x_zero = (x_in == '0);
		y_zero = (y_in == '0);
		side.special = x_zero || y_zero;
		side.undef = x_zero && y_zero;
		side.x_pos = !x_in[CW-1] && !x_zero;
		side.y_pos = !y_in[CW-1] && !y_zero;
		side.y_neg = y_in[CW-1];
		side.base_pi = x_in[CW-1];
		if (x_zero && y_zero) begin
			side.fixed_angle = ZERO_Q13;
		end else if (y_zero) begin
			side.fixed_angle = x_in[CW-1] ? PI_Q13 : ZERO_Q13;
		end else if (y_in[CW-1]) begin
			side.fixed_angle = THREE_HALF_PI_Q13;
		end else begin
			side.fixed_angle = HALF_PI_Q13;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= xr;
			y_s1 <= yr;
			side_s1 <= side;
		end
	end

	assign out_vld = vld_s1;
	assign x_out = x_s1;
	assign y_out = y_s1;
	assign z_out = '0;
	assign side_out = side_s1;

endmodule

// ===== sv/afx_step.sv =====
module afx_step import afx_pkg::*; #(
	parameter int DW = 42,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_vld,
	input  logic signed [DW-1:0] x_in,
	input  logic signed [DW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  side_t                side_in,
	output logic                 out_vld,
	output logic signed [DW-1:0] x_out,
	output logic signed [DW-1:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output side_t                side_out
);

	localparam logic signed [ZW-1:0] ATAN = atan_q24(IDX);

	logic signed [DW-1:0] sx, sy, nx, ny;
	logic signed [ZW-1:0] nz;
	logic vld_s1;
	logic signed [DW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	side_t side_s1;

	always_comb begin
		sx = x_in >>> IDX;
		sy = y_in >>> IDX;
		if (!y_in[DW-1]) begin
			nx = x_in + sy;
			ny = y_in - sx;
			nz = z_in + ATAN;
		end else begin
			nx = x_in - sy;
			ny = y_in + sx;
			nz = z_in - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= nx;
			y_s1 <= ny;
			z_s1 <= nz;
			side_s1 <= side_in;
		end
	end

	assign out_vld = vld_s1;
	assign x_out = x_s1;
	assign y_out = y_s1;
	assign z_out = z_s1;
	assign side_out = side_s1;

endmodule

// ===== sv/afx_post.sv =====
module afx_post import afx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           adv,
	input  logic                 in_vld,
	input  logic signed [ZW-1:0] z_in,
	input  side_t                side_in,
	output logic [1:0]           vld,
	output logic [AW-1:0]        angle,
	output logic                 undef
);

	logic signed [ZW-1:0] zg;
	logic signed [TW-1:0] tot;
	logic signed [TW-1:0] wrapped, rnd;
	logic [RW-1:0] q;
	logic [AW-1:0] ang;
	logic vld_s1, vld_s2;
	logic signed [TW-1:0] total_s1;
	side_t side_s1;
	logic [AW-1:0] angle_s2;
	logic undef_s2;

	always_comb begin
		zg = z_in;
		if (side_in.x_pos && side_in.y_pos && z_in[ZW-1]) begin
			zg = '0;
		end
		if (side_in.x_pos && side_in.y_neg && !z_in[ZW-1]) begin
			zg = '1;
		end
		tot = (side_in.base_pi ? PI_Q24 : '0) + TW'(zg);
	end

	always_comb begin
		wrapped = total_s1[TW-1] ? total_s1 + TWO_PI_Q24 : total_s1;
		if (wrapped[TW-1]) begin
			wrapped = '0;
		end
		rnd = wrapped + ROUND_HALF;
		q = rnd[TW-2:FRAC_BITS-13];
		if (q > ANGLE_MAX_Q13) begin
			ang = ANGLE_MAX_Q13[AW-1:0];
		end else begin
			ang = q[AW-1:0];
		end
		if (side_s1.special) begin
			ang = side_s1.fixed_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv[0]) begin
				vld_s1 <= in_vld;
			end
			if (adv[1]) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			total_s1 <= tot;
			side_s1 <= side_in;
		end
		if (adv[1]) begin
			angle_s2 <= ang;
			undef_s2 <= side_s1.undef;
		end
	end

	assign vld = {vld_s2, vld_s1};
	assign angle = angle_s2;
	assign undef = undef_s2;

endmodule

// ===== sv/angle_from_xy.sv =====
// Polar angle of a signed 2-D vector, as unsigned Q3.13 radians in [0, 2*pi).
// The input channel carries x_coord and y_coord with in_valid and in_stall; the
// output channel carries angle and undefined with out_valid and out_stall.
// A transaction completes on a rising edge where valid is high and stall is low.
// The zero vector gives angle 0 with undefined set; points on an axis get exact
// constants, and all others go through one CORDIC vectoring step per stage.
// The pipeline has one input stage that folds the left half plane over,
// ITERATIONS rotation stages, and two stages that fix the quadrant, round and
// saturate. Steps beyond 24 are not built.
// One transaction per cycle without output stall; each stage is one adder row.
// Each stage holds a valid bit and loads when it is empty or the stage after it
// loads, so a stalled output freezes only the full stages behind it and bubbles
// are squeezed out; in_stall rises when all stages are full and output stalls.
// Reset clears all valid bits; the pipeline is empty and out_valid is low.
module angle_from_xy import afx_pkg::*; #(
	parameter int ITERATIONS = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_WIDTH-1:0] x_coord,
	input  logic [COORD_WIDTH-1:0] y_coord,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [AW-1:0]          angle,
	output logic                   undefined
);

	localparam int NSTEP = (ITERATIONS > MAX_STEPS) ? MAX_STEPS : ITERATIONS;
	localparam int DW = COORD_WIDTH + FRAC_BITS + 2;
	localparam int NS = NSTEP + 3;

	logic [NS:0] adv;
	logic [NSTEP:0] vld;
	logic [1:0] post_vld;
	logic signed [DW-1:0] xs [NSTEP+1];
	logic signed [DW-1:0] ys [NSTEP+1];
	logic signed [ZW-1:0] zs [NSTEP+1];
	side_t sides [NSTEP+1];

	always_comb begin
		adv[NS] = !out_stall;
		for (int k = NS - 1; k >= 0; k--) begin
			if (k <= NSTEP) begin
				adv[k] = !vld[k] || adv[k+1];
			end else begin
				adv[k] = !post_vld[k-NSTEP-1] || adv[k+1];
			end
		end
	end

	assign in_stall = !adv[0];

	afx_pre #(
		.CW(COORD_WIDTH),
		.DW(DW)
	) u_pre (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv[0]),
		.in_vld(in_valid),
		.x_in(x_coord),
		.y_in(y_coord),
		.out_vld(vld[0]),
		.x_out(xs[0]),
		.y_out(ys[0]),
		.z_out(zs[0]),
		.side_out(sides[0])
	);

	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		afx_step #(
			.DW(DW),
			.IDX(i)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv[i+1]),
			.in_vld(vld[i]),
			.x_in(xs[i]),
			.y_in(ys[i]),
			.z_in(zs[i]),
			.side_in(sides[i]),
			.out_vld(vld[i+1]),
			.x_out(xs[i+1]),
			.y_out(ys[i+1]),
			.z_out(zs[i+1]),
			.side_out(sides[i+1])
		);
	end

	afx_post u_post (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv[NS-1:NS-2]),
		.in_vld(vld[NSTEP]),
		.z_in(zs[NSTEP]),
		.side_in(sides[NSTEP]),
		.vld(post_vld),
		.angle(angle),
		.undef(undefined)
	);

	assign out_valid = post_vld[1];

endmodule
